// ===== sv/igmp_hme_pkg.sv =====
package igmp_hme_pkg;

  localparam int unsigned IFACE_BITS = 4;
  localparam int unsigned TIMER_BITS = 11;

  // command codes
  localparam logic [2:0] CMD_JOIN   = 3'd0;
  localparam logic [2:0] CMD_LEAVE  = 3'd1;
  localparam logic [2:0] CMD_QUERY  = 3'd2;
  localparam logic [2:0] CMD_REPORT = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  // result codes
  localparam logic [1:0] EV_REPORT = 2'd0;
  localparam logic [1:0] EV_LEAVE  = 2'd1;
  localparam logic [1:0] EV_FULL   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_SECOND   = 2'd0;
  localparam logic [1:0] CFG_MAX_REPORT_DELAY_S = 2'd1;
  localparam logic [1:0] CFG_SEED_INIT          = 2'd2;

  localparam logic [31:0] ALL_HOSTS   = 32'hE000_0001;
  localparam logic [31:0] ALL_ROUTERS = 32'hE000_0002;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  // x / 10 as (x * 52429) >> 19, exact for x below 262149
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [31:0]           group_addr;
    logic [IFACE_BITS-1:0] iface;
    logic [7:0]            max_resp_code;
    logic                  frame_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]            event_res;
    logic [31:0]           out_group;
    logic [31:0]           dest_addr;
    logic [IFACE_BITS-1:0] out_iface;
    logic                  last_of_run;
  } result_t;

  typedef struct packed {
    logic [31:0]           group;
    logic [IFACE_BITS-1:0] iface;
    logic [TIMER_BITS-1:0] timer;
    logic                  reported_last;
  } entry_t;

endpackage

// ===== sv/igmp_hme_ram.sv =====
module igmp_hme_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/igmp_host_membership_engine.sv =====
// igmpv2 host membership engine. a command is taken when start is high and busy is low;
// busy then stays high until every result of that command has gone out. results appear
// on result for one cycle each, marked by result_valid, and must be taken then: there is
// no back-pressure. join, leave and foreign report walk the table until the first match,
// then act in the act state; query and tick walk every entry. a table walk reads each
// entry in a read state and checks it in a check state, where a tick also writes it back;
// each timer started by a join or query adds a jitter draw, a 15-step remainder unit and
// a write-back. commands 5 to 7, queries and reports with a bad frame, and ticks with no
// timer running are taken without leaving idle and give no result.
module igmp_host_membership_engine #(
  parameter int GROUP_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  igmp_hme_pkg::item_t   item,
  output logic                  result_valid,
  output igmp_hme_pkg::result_t result,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int IDX_W = $clog2(GROUP_ENTRIES);
  localparam int TW    = igmp_hme_pkg::TIMER_BITS;
  localparam int ENT_W = $bits(igmp_hme_pkg::entry_t);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP1 = 4'd1;
  localparam logic [3:0] S_SETUP2 = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_ACT    = 4'd5;
  localparam logic [3:0] S_LCG    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  // configuration
  logic [5:0]  ticks_per_second;
  logic [4:0]  max_report_delay_s;
  logic [31:0] jitter_seed;

  // control
  logic [3:0]               state;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         fidx;
  logic                     found;
  logic                     still;
  logic                     any_timer_running;
  logic [GROUP_ENTRIES-1:0] entry_valid;
  igmp_hme_pkg::item_t      cur;
  igmp_hme_pkg::entry_t     cdata;

  // delay arithmetic
  logic [10:0] span_raw;
  logic [14:0] prod;
  logic [TW-1:0] den;
  logic [14:0] num;
  logic [TW-1:0] rem;
  logic [3:0]  cnt;

  // pending result, held back until we know whether another follows
  logic                  pend_v;
  igmp_hme_pkg::result_t pend;

  // table memory
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  igmp_hme_pkg::entry_t wr_data;
  igmp_hme_pkg::entry_t rd_entry;
  logic [ENT_W-1:0]     rd_raw;

  igmp_hme_ram #(.WIDTH(ENT_W), .DEPTH(GROUP_ENTRIES)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx),
    .rd_data (rd_raw)
  );

  assign rd_entry = rd_raw;
  assign busy = (state != S_IDLE);

  logic cur_valid, hit, qcond, last_idx;
  logic [TW-1:0] tick_dec;
  logic [TW-1:0] new_timer;
  logic [8:0]  resp;
  logic [29:0] tprod;
  logic [TW-1:0] tq;
  logic [31:0] seed_mul;
  logic [TW:0] r2;
  logic [TW:0] r2_sub;
  logic        free_found;
  logic [IDX_W-1:0] free_idx;
  logic        emit_req;
  igmp_hme_pkg::result_t emit_item;

  assign cur_valid = entry_valid[idx];
  assign hit = cur_valid && rd_entry.group == cur.group_addr && rd_entry.iface == cur.iface;
  assign qcond = cur_valid && rd_entry.iface == cur.iface
              && rd_entry.group != igmp_hme_pkg::ALL_HOSTS
              && (cur.group_addr == 32'd0 || cur.group_addr == rd_entry.group)
              && (rd_entry.timer == '0 || rd_entry.timer > den);
  assign last_idx  = (idx == IDX_W'(GROUP_ENTRIES - 1));
  assign tick_dec  = rd_entry.timer - TW'(1);
  assign new_timer = rem + TW'(1);

  assign resp  = (cur.max_resp_code == 8'd0) ? 9'(max_report_delay_s * 4'd10)
                                              : {1'b0, cur.max_resp_code};
  assign tprod = 30'(prod * igmp_hme_pkg::DIV10_MUL);
  assign tq    = TW'(tprod >> igmp_hme_pkg::DIV10_SHIFT);

  assign seed_mul = 32'(jitter_seed * igmp_hme_pkg::LCG_MUL) + igmp_hme_pkg::LCG_ADD;

  // one restoring step of the remainder unit
  assign r2     = {rem, num[14]};
  assign r2_sub = r2 - {1'b0, den};

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = GROUP_ENTRIES - 1; k >= 0; k--) begin
      if (!entry_valid[k]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(k);
      end
    end
  end

  // memory writes and results
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_data   = rd_entry;
    emit_req  = 1'b0;
    emit_item = '0;
    case (state)
      S_CHK: begin
        if (cur.cmd == igmp_hme_pkg::CMD_TICK && cur_valid && rd_entry.timer != '0) begin
          wr_en         = 1'b1;
          wr_data.timer = tick_dec;
          if (tick_dec == '0) begin
            wr_data.reported_last = 1'b1;
            emit_req  = 1'b1;
            emit_item = '{igmp_hme_pkg::EV_REPORT, rd_entry.group, rd_entry.group,
                          rd_entry.iface, 1'b0};
          end
        end
      end
      S_ACT: begin
        case (cur.cmd)
          igmp_hme_pkg::CMD_JOIN: begin
            if (!found && free_found) begin
              if (cur.group_addr == igmp_hme_pkg::ALL_HOSTS) begin
                wr_en   = 1'b1;
                wr_addr = free_idx;
                wr_data = '{cur.group_addr, cur.iface, '0, 1'b0};
              end else begin
                emit_req  = 1'b1;
                emit_item = '{igmp_hme_pkg::EV_REPORT, cur.group_addr, cur.group_addr,
                              cur.iface, 1'b0};
              end
            end else if (!found) begin
              emit_req  = 1'b1;
              emit_item = '{igmp_hme_pkg::EV_FULL, cur.group_addr, 32'd0, cur.iface, 1'b0};
            end
          end
          igmp_hme_pkg::CMD_LEAVE: begin
            if (found && cdata.reported_last && cur.group_addr != igmp_hme_pkg::ALL_HOSTS) begin
              emit_req  = 1'b1;
              emit_item = '{igmp_hme_pkg::EV_LEAVE, cur.group_addr, igmp_hme_pkg::ALL_ROUTERS,
                            cur.iface, 1'b0};
            end
          end
          igmp_hme_pkg::CMD_REPORT: begin
            if (found) begin
              wr_en   = 1'b1;
              wr_addr = fidx;
              wr_data = '{cdata.group, cdata.iface, '0, 1'b0};
            end
          end
          default: begin
          end
        endcase
      end
      S_WR: begin
        wr_en = 1'b1;
        if (cur.cmd == igmp_hme_pkg::CMD_JOIN) begin
          wr_addr = fidx;
          wr_data = '{cur.group_addr, cur.iface, new_timer, 1'b1};
        end else begin
          wr_data = '{cdata.group, cdata.iface, new_timer, cdata.reported_last};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      ticks_per_second   <= 6'd5;
      max_report_delay_s <= 5'd10;
      jitter_seed        <= 32'd1;
      any_timer_running  <= 1'b0;
      entry_valid        <= '0;
      pend_v             <= 1'b0;
      result_valid       <= 1'b0;
      idx                <= '0;
      found              <= 1'b0;
      still              <= 1'b0;
    end else begin
      result_valid <= 1'b0;

      // a new result pushes out the one held back, marked not last
      if (emit_req) begin
        if (pend_v) begin
          result       <= pend;
          result_valid <= 1'b1;
        end
        pend   <= emit_item;
        pend_v <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (cfg_wr_en) begin
            case (cfg_index)
              igmp_hme_pkg::CFG_TICKS_PER_SECOND:   ticks_per_second   <= cfg_data[5:0];
              igmp_hme_pkg::CFG_MAX_REPORT_DELAY_S: max_report_delay_s <= cfg_data[4:0];
              igmp_hme_pkg::CFG_SEED_INIT:          jitter_seed        <= cfg_data;
              default: begin
              end
            endcase
          end
          if (start) begin
            cur   <= item;
            idx   <= '0;
            found <= 1'b0;
            still <= 1'b0;
            case (item.cmd)
              igmp_hme_pkg::CMD_JOIN, igmp_hme_pkg::CMD_LEAVE: state <= S_SETUP1;
              igmp_hme_pkg::CMD_QUERY, igmp_hme_pkg::CMD_REPORT: begin
                if (item.frame_ok) state <= S_SETUP1;
              end
              igmp_hme_pkg::CMD_TICK: begin
                if (any_timer_running) state <= S_SETUP1;
              end
              default: begin
              end
            endcase
          end
        end
        S_SETUP1: begin
          span_raw <= 11'(max_report_delay_s * ticks_per_second);
          prod     <= 15'(resp * ticks_per_second);
          state    <= S_SETUP2;
        end
        S_SETUP2: begin
          if (cur.cmd == igmp_hme_pkg::CMD_JOIN) begin
            den <= (span_raw == '0) ? TW'(1) : span_raw;
          end else begin
            den <= (tq == '0) ? TW'(1) : tq;
          end
          state <= S_RD;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          case (cur.cmd)
            igmp_hme_pkg::CMD_QUERY: begin
              if (qcond) begin
                cdata <= rd_entry;
                state <= S_LCG;
              end else if (last_idx) begin
                state <= S_FIN;
              end else begin
                idx   <= idx + IDX_W'(1);
                state <= S_RD;
              end
            end
            igmp_hme_pkg::CMD_TICK: begin
              if (cur_valid && rd_entry.timer != '0 && tick_dec != '0) still <= 1'b1;
              if (last_idx) begin
                state <= S_FIN;
              end else begin
                idx   <= idx + IDX_W'(1);
                state <= S_RD;
              end
            end
            default: begin
              // join, leave and foreign report look for the first match
              if (hit) begin
                found <= 1'b1;
                fidx  <= idx;
                cdata <= rd_entry;
                state <= S_ACT;
              end else if (last_idx) begin
                state <= S_ACT;
              end else begin
                idx   <= idx + IDX_W'(1);
                state <= S_RD;
              end
            end
          endcase
        end
        S_ACT: begin
          state <= S_FIN;
          case (cur.cmd)
            igmp_hme_pkg::CMD_JOIN: begin
              if (!found && free_found) begin
                entry_valid[free_idx] <= 1'b1;
                fidx <= free_idx;
                if (cur.group_addr != igmp_hme_pkg::ALL_HOSTS) state <= S_LCG;
              end
            end
            igmp_hme_pkg::CMD_LEAVE: begin
              if (found) entry_valid[fidx] <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        S_LCG: begin
          jitter_seed <= seed_mul;
          num         <= seed_mul[30:16];
          rem         <= '0;
          cnt         <= 4'd15;
          state       <= S_DIV;
        end
        S_DIV: begin
          rem <= r2_sub[TW] ? r2[TW-1:0] : r2_sub[TW-1:0];
          num <= {num[13:0], 1'b0};
          cnt <= cnt - 4'd1;
          if (cnt == 4'd1) state <= S_WR;
        end
        S_WR: begin
          any_timer_running <= 1'b1;
          if (cur.cmd == igmp_hme_pkg::CMD_JOIN || last_idx) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_RD;
          end
        end
        S_FIN: begin
          // the held-back result goes out marked last
          if (pend_v) begin
            result       <= '{pend.event_res, pend.out_group, pend.dest_addr,
                              pend.out_iface, 1'b1};
            result_valid <= 1'b1;
            pend_v       <= 1'b0;
          end
          if (cur.cmd == igmp_hme_pkg::CMD_TICK) any_timer_running <= still;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
